// ===== hdl/chm_pkg.sv =====
// Shared types and constants for the chained hash map.
package chm_pkg;

  localparam int DEF_BUCKETS  = 64;
  localparam int DEF_CAPACITY = 256;

  localparam int          HASH_SHIFT = 33;
  localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [63:0] value;
  } chm_req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
  } chm_res_t;

endpackage

// ===== hdl/chained_hash_map_unit.sv =====
// Top level of the chained hash map: input capture, output register, hash and table.
//
// Usage:
//   Input channel in_valid/in_stall carries one operation per transaction:
//   in_op (0 put, 1 get, 2 remove, 3 clear), in_key, in_value_in.
//   Output channel out_valid/out_stall returns exactly one transaction per
//   operation: out_status, out_value_out, out_entry_total, in order.
//   One operation is in flight at a time. The hash runs two multiplies
//   (three 32x32 partial products each, on one shared multiplier), then
//   the remainder a byte at a time and a done state. The table then reads
//   the bucket head and walks the chain; a remove also relinks the chain
//   and pushes the freed node on the free stack, and an insert puts the new
//   node at the chain head, first popping the free stack if it reuses one.
//   The next transaction is taken the cycle after the result enters the
//   output register. A clear rewrites every bucket head.
//   After reset the bucket-head memory is swept while in_stall stays high.
//   When out_stall holds a result in the output register, the next
//   operation is still taken and worked on; it waits in the table until the
//   output register frees up.
module chained_hash_map_unit #(
  parameter int BUCKETS  = chm_pkg::DEF_BUCKETS,
  parameter int CAPACITY = chm_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_value_out,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_total
);
  import chm_pkg::*;

  localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW  = $clog2(CAPACITY + 1);

  logic           busy_r, busy_nxt;
  chm_req_t       req_r, req_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [63:0]    vout_r, vout_nxt;
  logic [NW-1:0]  total_r, total_nxt;

  logic           in_acc, hash_done, tbl_valid, tbl_init, take, load;
  logic [BIW-1:0] bucket;
  chm_res_t       tbl_res;
  logic [NW-1:0]  tbl_total;

  assign in_stall = busy_r | tbl_init;
  assign in_acc   = in_valid & ~in_stall;
  assign take     = ~out_valid_r | ~out_stall;
  assign load     = tbl_valid & take;

  chm_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .key    (in_key),
    .done   (hash_done),
    .bucket (bucket)
  );

  chm_table #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (hash_done),
    .req       (req_r),
    .bkt       (bucket),
    .take      (take),
    .res_valid (tbl_valid),
    .res       (tbl_res),
    .res_total (tbl_total),
    .init_busy (tbl_init)
  );

  always_comb begin
    busy_nxt      = busy_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    total_nxt     = total_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      req_nxt  = '{op: op_t'(in_op), key: in_key, value: in_value_in};
    end
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load) begin
      // result moves to the output register, item slot frees up
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      status_nxt    = tbl_res.status;
      vout_nxt      = tbl_res.value;
      total_nxt     = tbl_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    total_r  <= total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = vout_r;
  assign out_entry_total = total_r;

  // table only reports while an operation is pending
  a_res_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_valid |-> busy_r) else $error("table result without pending item");

  // hash finishes only for a pending operation
  a_hash_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> busy_r) else $error("hash done without pending item");

  // entry count never exceeds the node pool
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (total_r <= NW'(CAPACITY))) else $error("entry total over capacity");

  // a failed operation (miss or full) never returns data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (vout_r == '0))
    else $error("nonzero value on failed operation");

endmodule

// ===== hdl/chm_hash.sv =====
// Murmur finalizer on a shared 32x32 multiplier, then bucket remainder a byte per cycle.
module chm_hash #(
  parameter int BUCKETS = chm_pkg::DEF_BUCKETS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
  import chm_pkg::*;

  localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW  = $clog2(BUCKETS + 1);
  localparam logic [RW:0] BMOD = (RW + 1)'(BUCKETS);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_MOD, H_DONE} hstate_t;

  hstate_t     state_r, state_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        m_r, m_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [RW-1:0] rem_r, rem_nxt;

  logic [63:0] cst, sum;
  logic [31:0] opa, opb;
  logic [RW:0] t;

  always_comb begin
    cst = m_r ? MIX_C2 : MIX_C1;
    case (ph_r)
      2'd0:    begin opa = x_r[31:0];  opb = cst[31:0];  end
      2'd1:    begin opa = x_r[63:32]; opb = cst[31:0];  end
      default: begin opa = x_r[31:0];  opb = cst[63:32]; end
    endcase
    sum = acc_r + {prod_r[31:0], 32'd0};
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    prod_nxt  = {32'd0, opa} * {32'd0, opb};
    ph_nxt    = ph_r;
    m_nxt     = m_r;
    byte_nxt  = byte_r;
    rem_nxt   = rem_r;
    t         = '0;
    unique case (state_r)
      H_IDLE: begin
        if (start) begin
          x_nxt     = key ^ (key >> HASH_SHIFT);
          ph_nxt    = 2'd0;
          m_nxt     = 1'b0;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        ph_nxt = ph_r + 2'd1;
        case (ph_r)
          2'd1:    acc_nxt = prod_r;
          2'd2:    acc_nxt = sum;
          2'd3: begin
            x_nxt = sum ^ (sum >> HASH_SHIFT);
            m_nxt = 1'b1;
            if (m_r) begin
              state_nxt = H_MOD;
              byte_nxt  = 3'd0;
              rem_nxt   = '0;
            end
          end
          default: ;
        endcase
      end
      H_MOD: begin
        // remainder of x by BUCKETS, MSB first, one compare-subtract per bit
        for (int i = 7; i >= 0; i--) begin
          t = {rem_nxt, x_r[56 + i]};
          if (t >= BMOD) t = t - BMOD;
          rem_nxt = t[RW-1:0];
        end
        x_nxt    = {x_r[55:0], 8'd0};
        byte_nxt = byte_r + 3'd1;
        if (byte_r == 3'd7) state_nxt = H_DONE;
      end
      H_DONE: state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    ph_r   <= ph_nxt;
    m_r    <= m_nxt;
    byte_r <= byte_nxt;
    rem_r  <= rem_nxt;
  end

  assign done   = (state_r == H_DONE);
  assign bucket = BIW'(rem_r);

endmodule

// ===== hdl/chm_table.sv =====
// Bucket-head and node memories with the chain-walk sequencer.
module chm_table #(
  parameter int BUCKETS  = chm_pkg::DEF_BUCKETS,
  parameter int CAPACITY = chm_pkg::DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  chm_pkg::chm_req_t    req,
  input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bkt,
  input  logic                 take,
  output logic                 res_valid,
  output chm_pkg::chm_res_t    res,
  output logic [$clog2(CAPACITY+1)-1:0] res_total,
  output logic                 init_busy
);
  import chm_pkg::*;

  localparam int BIW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW    = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int ROW_W = 128 + NW;
  localparam logic [NW-1:0]  NIL   = NW'(CAPACITY);
  localparam logic [BIW-1:0] BLAST = BIW'(BUCKETS - 1);

  typedef enum logic [3:0] {
    T_SWEEP, T_IDLE, T_HEAD, T_CMP, T_REM, T_MISS, T_ALLOC, T_INS, T_DONE
  } tstate_t;

  logic [NW-1:0]    bucket_mem [BUCKETS];
  logic [ROW_W-1:0] node_mem   [CAPACITY];

  logic             bm_we, bm_re, nm_we, nm_re;
  logic [BIW-1:0]   bm_wa, bm_ra;
  logic [NW-1:0]    bm_wd, bh_q;
  logic [AW-1:0]    nm_wa, nm_ra;
  logic [ROW_W-1:0] nm_wd, nd_q;

  tstate_t          state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [63:0]      key_r, key_nxt, val_r, val_nxt;
  logic [BIW-1:0]   bkt_r, bkt_nxt, sweep_r, sweep_nxt;
  logic [NW-1:0]    cur_r, cur_nxt, prev_r, prev_nxt, head_r, head_nxt;
  logic [NW-1:0]    free_r, free_nxt, fill_r, fill_nxt, count_r, count_nxt;
  logic [ROW_W-1:0] hit_r, hit_nxt, prow_r, prow_nxt;
  logic             pend_r, pend_nxt;
  status_t          status_r, status_nxt;
  logic [63:0]      vout_r, vout_nxt;

  logic [63:0]   nd_key, nd_val;
  logic [NW-1:0] nd_link;

  assign nd_key  = nd_q[ROW_W-1 -: 64];
  assign nd_val  = nd_q[NW +: 64];
  assign nd_link = nd_q[NW-1:0];

  always_ff @(posedge clk) begin
    if (bm_we) bucket_mem[bm_wa] <= bm_wd;
    if (bm_re) bh_q <= bucket_mem[bm_ra];
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    if (nm_re) nd_q <= node_mem[nm_ra];
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    bkt_nxt    = bkt_r;
    sweep_nxt  = sweep_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    free_nxt   = free_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    prow_nxt   = prow_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    bm_we = 1'b0; bm_wa = bkt_r; bm_wd = NIL;
    bm_re = 1'b0; bm_ra = bkt;
    nm_we = 1'b0; nm_wa = cur_r[AW-1:0]; nm_wd = '0;
    nm_re = 1'b0; nm_ra = cur_r[AW-1:0];
    unique case (state_r)
      T_SWEEP: begin
        bm_we = 1'b1;
        bm_wa = sweep_r;
        if (sweep_r == BLAST) begin
          state_nxt = pend_r ? T_DONE : T_IDLE;
          pend_nxt  = 1'b0;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      T_IDLE: begin
        if (start) begin
          op_nxt     = req.op;
          key_nxt    = req.key;
          val_nxt    = req.value;
          bkt_nxt    = bkt;
          status_nxt = ST_OK;
          vout_nxt   = '0;
          if (req.op == OP_CLEAR) begin
            sweep_nxt = '0;
            pend_nxt  = 1'b1;
            free_nxt  = NIL;
            fill_nxt  = '0;
            count_nxt = '0;
            state_nxt = T_SWEEP;
          end else begin
            bm_re     = 1'b1;
            state_nxt = T_HEAD;
          end
        end
      end
      T_HEAD: begin
        head_nxt = bh_q;
        cur_nxt  = bh_q;
        prev_nxt = NIL;
        if (bh_q >= NIL) begin
          state_nxt = T_MISS;
        end else begin
          nm_re     = 1'b1;
          nm_ra     = bh_q[AW-1:0];
          state_nxt = T_CMP;
        end
      end
      T_CMP: begin
        if (nd_key == key_r) begin
          hit_nxt   = nd_q;
          state_nxt = T_DONE;
          case (op_r)
            OP_PUT: begin
              nm_we = 1'b1;
              nm_wd = {key_r, val_r, nd_link};
            end
            OP_GET: vout_nxt = nd_val;
            OP_REMOVE: begin
              vout_nxt = nd_val;
              if (prev_r >= NIL) begin
                bm_we = 1'b1;
                bm_wd = nd_link;
              end else begin
                nm_we = 1'b1;
                nm_wa = prev_r[AW-1:0];
                nm_wd = {prow_r[ROW_W-1:NW], nd_link};
              end
              if (count_r != '0) count_nxt = count_r - 1'b1;
              state_nxt = T_REM;
            end
            default: ;
          endcase
        end else begin
          prev_nxt = cur_r;
          prow_nxt = nd_q;
          cur_nxt  = nd_link;
          if (nd_link >= NIL) begin
            state_nxt = T_MISS;
          end else begin
            nm_re = 1'b1;
            nm_ra = nd_link[AW-1:0];
          end
        end
      end
      T_REM: begin
        // freed node goes on top of the free stack
        nm_we     = 1'b1;
        nm_wd     = {hit_r[ROW_W-1:NW], free_r};
        free_nxt  = cur_r;
        state_nxt = T_DONE;
      end
      T_MISS: begin
        state_nxt = T_DONE;
        if (op_r == OP_PUT) begin
          if (free_r < NIL) begin
            nm_re     = 1'b1;
            nm_ra     = free_r[AW-1:0];
            cur_nxt   = free_r;
            state_nxt = T_ALLOC;
          end else if (fill_r < NIL) begin
            // never-used nodes are handed out in index order
            cur_nxt   = fill_r;
            fill_nxt  = fill_r + 1'b1;
            state_nxt = T_INS;
          end else begin
            status_nxt = ST_FULL;
          end
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      T_ALLOC: begin
        free_nxt  = nd_link;
        state_nxt = T_INS;
      end
      T_INS: begin
        nm_we     = 1'b1;
        nm_wd     = {key_r, val_r, head_r};
        bm_we     = 1'b1;
        bm_wd     = cur_r;
        count_nxt = count_r + 1'b1;
        state_nxt = T_DONE;
      end
      T_DONE: begin
        if (take) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_SWEEP;
      sweep_r <= '0;
      pend_r  <= 1'b0;
      free_r  <= NIL;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      pend_r  <= pend_nxt;
      free_r  <= free_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    bkt_r    <= bkt_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    head_r   <= head_nxt;
    hit_r    <= hit_nxt;
    prow_r   <= prow_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
  end

  assign res_valid  = (state_r == T_DONE);
  assign res.status = status_r;
  assign res.value  = vout_r;
  assign res_total  = count_r;
  assign init_busy  = (state_r == T_SWEEP) && !pend_r;

endmodule
